// ===== rtl/priority_fifo_ready_queue_top_defines.svh =====
// Assertion macros for the priority ready queue.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef PRIORITY_FIFO_READY_QUEUE_TOP_DEFINES_SVH
`define PRIORITY_FIFO_READY_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication.
`define PFQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PFQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pfq_pkg.sv =====
// Shared types and constants for the priority ready queue.
// No dependencies.
package pfq_pkg;

  localparam int DEPTH   = 16;
  localparam int ID_W    = 6;
  localparam int PRIO_W  = 8;
  localparam int OCC_W   = 5;
  localparam int COUNT_W = $clog2(DEPTH + 1);

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  // Broadcast from the control to every cell.
  typedef struct packed {
    logic   ins;
    logic   deq;
    entry_t item;
  } cell_ctrl_t;

endpackage

// ===== rtl/pfq_if.sv =====
// Handshake channels of the priority ready queue: request and response.
// Depends on pfq_pkg.
interface pfq_req_if import pfq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [ID_W-1:0]   proc_id;
  logic [PRIO_W-1:0] proc_priority;

  modport source (output valid, opcode, proc_id, proc_priority, input ready);
  modport sink   (input valid, opcode, proc_id, proc_priority, output ready);
endinterface

interface pfq_rsp_if import pfq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              out_valid;
  logic [ID_W-1:0]   out_id;
  logic [PRIO_W-1:0] out_priority;
  logic [1:0]        status;
  logic [OCC_W-1:0]  occupancy;

  modport source (output valid, out_valid, out_id, out_priority, status, occupancy,
                  input ready);
  modport sink   (input valid, out_valid, out_id, out_priority, status, occupancy,
                  output ready);
endinterface

// ===== rtl/pfq_cell.sv =====
// One slot of the sorted shift-register queue.
// Depends on pfq_pkg.
module pfq_cell import pfq_pkg::*; (
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  logic       occupied_i,
  input  entry_t     left_i,
  input  logic       left_gt_i,
  input  entry_t     right_i,
  output entry_t     entry_o,
  output logic       gt_o
);

  entry_t entry_q, entry_d;

  // New item outranks this slot (empty slots always lose).
  assign gt_o = !occupied_i || (ctrl_i.item.prio > entry_q.prio);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (gt_o && left_gt_i) begin
        entry_d = left_i;
      end else if (gt_o) begin
        entry_d = ctrl_i.item;
      end
    end else if (ctrl_i.deq) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== rtl/priority_fifo_ready_queue_top.sv =====
// Latency: a result is presented the cycle after its item is accepted.
// Throughput: one item per cycle while the response side keeps draining; every cell compares and shifts in parallel.
// Input is taken while the output register is empty or being drained.
// Reset clears the entry count and the pending output beat; slot contents
// are left as is and are never read before written.
`include "priority_fifo_ready_queue_top_defines.svh"

module priority_fifo_ready_queue_top import pfq_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  pfq_req_if.sink    req_i,
  pfq_rsp_if.source  rsp_o
);

  logic [COUNT_W-1:0] count_q, count_d;
  logic               pend_q, pend_d;
  logic               res_valid_q, res_valid_d;
  entry_t             res_entry_q, res_entry_d;
  status_e            res_status_q, res_status_d;

  logic               accept, is_deq, full, empty;
  cell_ctrl_t         ctrl;
  entry_t             cell_entry [DEPTH];
  entry_t             left_entry [DEPTH];
  entry_t             right_entry[DEPTH];
  logic [DEPTH-1:0]   gt;
  logic [DEPTH-1:0]   left_gt;
  logic [DEPTH-1:0]   occupied;

  assign req_i.ready = !pend_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign is_deq      = (req_i.opcode == OP_DEQ);
  assign full        = (count_q == COUNT_W'(DEPTH));
  assign empty       = (count_q == '0);

  assign ctrl.ins       = accept && !is_deq && !full;
  assign ctrl.deq       = accept && is_deq && !empty;
  assign ctrl.item.id   = req_i.proc_id;
  assign ctrl.item.prio = req_i.proc_priority;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    localparam logic [COUNT_W-1:0] Idx = COUNT_W'(k);

    assign occupied[k] = Idx < count_q;

    if (k == 0) begin : g_head
      assign left_entry[k] = '0;
      assign left_gt[k]    = 1'b0;
    end else begin : g_body
      assign left_entry[k] = cell_entry[k-1];
      assign left_gt[k]    = gt[k-1];
    end

    if (k == DEPTH - 1) begin : g_tail
      assign right_entry[k] = '0;
    end else begin : g_inner
      assign right_entry[k] = cell_entry[k+1];
    end

    pfq_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .occupied_i (occupied[k]),
      .left_i     (left_entry[k]),
      .left_gt_i  (left_gt[k]),
      .right_i    (right_entry[k]),
      .entry_o    (cell_entry[k]),
      .gt_o       (gt[k])
    );
  end

  always_comb begin
    count_d      = count_q;
    pend_d       = pend_q;
    res_valid_d  = res_valid_q;
    res_entry_d  = res_entry_q;
    res_status_d = res_status_q;
    if (rsp_o.ready) begin
      pend_d = 1'b0;
    end
    if (accept) begin
      pend_d       = 1'b1;
      res_valid_d  = 1'b0;
      res_entry_d  = '0;
      res_status_d = ST_OK;
      if (is_deq) begin
        if (empty) begin
          res_status_d = ST_EMPTY;
        end else begin
          res_valid_d = 1'b1;
          res_entry_d = cell_entry[0];
          count_d     = count_q - 1'b1;
        end
      end else begin
        if (full) begin
          res_status_d = ST_FULL;
        end else begin
          count_d = count_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_valid_q  <= res_valid_d;
    res_entry_q  <= res_entry_d;
    res_status_q <= res_status_d;
  end

  // Occupancy reflects the count right after the item.
  logic [OCC_W-1:0] occ_q;
  always_ff @(posedge clk_i) begin
    if (accept) begin
      occ_q <= OCC_W'(count_d);
    end
  end

  assign rsp_o.valid        = pend_q;
  assign rsp_o.out_valid    = res_valid_q;
  assign rsp_o.out_id       = res_entry_q.id;
  assign rsp_o.out_priority = res_entry_q.prio;
  assign rsp_o.status       = res_status_q;
  assign rsp_o.occupancy    = occ_q;

  `PFQ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= COUNT_W'(DEPTH), "count above depth")
  `PFQ_ASSERT_NOW(a_head_sorted, count_q >= COUNT_W'(2),
                  cell_entry[0].prio >= cell_entry[1].prio, "head not highest priority")
  `PFQ_ASSERT_NEXT(a_deq_count, ctrl.deq, count_q == $past(count_q) - 1'b1,
                   "dequeue did not drop count")
  `PFQ_ASSERT_NEXT(a_empty_result, accept && is_deq && empty,
                   !res_valid_q && res_status_q == ST_EMPTY, "bad empty dequeue result")

endmodule
